@@ rtl/ravc_pkg.sv @@
// Package for the RGBA average colour block: widths, lane count and the
// control bundle passed from the sequencer to the channel lanes.
// No dependencies.
`default_nettype none

package ravc_pkg;

  localparam longint unsigned MaxPixels = 64'd16777216;

  localparam int unsigned NumLanes = 4;   // red, green, blue, alpha
  localparam int unsigned PixW     = 8;   // one channel sample
  localparam int unsigned MeanW    = 8;   // one channel mean
  localparam int unsigned CntW     = $clog2(MaxPixels + 64'd1);
  localparam int unsigned SumW     = $clog2(64'd255 * MaxPixels + 64'd1);
  // shifted divisor and trial remainder; the mean never exceeds 255
  localparam int unsigned CmpW     = CntW + MeanW;
  localparam int unsigned StepW    = $clog2(MeanW);

  typedef struct packed {
    logic acc_en;  // add this beat's sample into the running sum
    logic load;    // last beat: move the sum into the divider, clear sum
    logic step;    // one restoring division step
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StHold = 3'b100
  } ctrl_state_e;

endpackage

`default_nettype wire

@@ rtl/ravc_lane.sv @@
// One channel lane: running sum plus a restoring divider, one quotient bit
// per step. Depends on ravc_pkg.
`default_nettype none

module ravc_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ravc_pkg::lane_ctrl_t              ctrl_i,
  input  wire logic [ravc_pkg::PixW-1:0]         pix_i,
  input  wire logic [ravc_pkg::CmpW-1:0]         dsh_i,   // divisor, pre-shifted
  output logic      [ravc_pkg::MeanW-1:0]        quo_o
);

  logic [ravc_pkg::SumW-1:0]  sum_q, sum_d, sum_add;
  logic [ravc_pkg::SumW-1:0]  rem_q;
  logic [ravc_pkg::MeanW-1:0] quo_q;
  logic [ravc_pkg::CmpW-1:0]  rem_ext, diff;
  logic                       fits;

  always_comb begin
    sum_add = sum_q + ravc_pkg::SumW'(pix_i);
    sum_d   = sum_q;
    if (ctrl_i.load) begin
      sum_d = '0;
    end else if (ctrl_i.acc_en) begin
      sum_d = sum_add;
    end
    rem_ext = ravc_pkg::CmpW'(rem_q);
    fits    = (rem_ext >= dsh_i);
    diff    = rem_ext - dsh_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // divider datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= ctrl_i.acc_en ? sum_add : sum_q;
      quo_q <= '0;
    end else if (ctrl_i.step) begin
      if (fits) begin
        rem_q <= diff[ravc_pkg::SumW-1:0];
      end
      quo_q <= {quo_q[ravc_pkg::MeanW-2:0], fits};
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/ravc_merge.sv @@
// Merge stage: gathers the lane quotients into one output beat and holds
// it until taken. Depends on ravc_pkg.
`default_nettype none

module ravc_merge (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           load_i,
  input  wire logic [ravc_pkg::NumLanes-1:0][ravc_pkg::MeanW-1:0] quo_i,
  output logic                                                free_o,
  output logic                                                m_axis_tvalid_o,
  input  wire logic                                           m_axis_tready_i,
  output logic [ravc_pkg::NumLanes*ravc_pkg::MeanW-1:0]       m_axis_tdata_o
);

  logic                                               valid_q, valid_d;
  logic [ravc_pkg::NumLanes*ravc_pkg::MeanW-1:0]      data_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= quo_i;  // lane 0 (red) in the low byte
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/rgba_average_color.sv @@
// RGBA average colour: top level with pixel counter and division sequencer.
// Depends on ravc_pkg, ravc_lane, ravc_merge.
//
// Usage:
//  - Input stream: one RGBA pixel per beat; tlast marks the last pixel of a
//    picture. Each channel has its own lane with a running sum; a shared
//    counter counts pixels and saturates at MaxPixels (pixels beyond that
//    are dropped, but a tlast on them still closes the picture).
//  - Output stream: one beat per picture carrying the truncated mean of
//    each channel, red in the low byte.
//  - Throughput: one pixel per cycle inside a picture. After the last pixel
//    the input stalls while the four lanes run an 8-step restoring division
//    in parallel (one quotient bit per cycle) and hand the result to the
//    output register.
//  - Result: once the last beat is taken, the lanes divide in StDiv; the
//    result is then loaded from StHold into the output register when it is free.
//  - Receiver stall: the result waits in the output register; the block
//    keeps taking the next picture's pixels meanwhile, and only holds off
//    the next finished picture until the register is free.
//  - Reset: sums, count and output valid clear; the block is ready at once.
`default_nettype none

module rgba_average_color (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // red, green, blue, alpha
  input  wire logic        s_axis_tlast_i,   // last_pixel
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // mean_red, mean_green, mean_blue, mean_alpha
);

  ravc_pkg::ctrl_state_e                     state_q, state_d;
  logic [ravc_pkg::CntW-1:0]                 cnt_q, cnt_d, cnt_nxt;
  logic [ravc_pkg::CmpW-1:0]                 dsh_q, dsh_d;
  logic [ravc_pkg::StepW-1:0]                step_q, step_d;
  logic                                      accept, room, merge_load, merge_free;
  ravc_pkg::lane_ctrl_t                      lane_ctrl;
  logic [ravc_pkg::NumLanes-1:0][ravc_pkg::MeanW-1:0] quo;

  assign s_axis_tready_o = (state_q == ravc_pkg::StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  // saturating count: beats past the bound leave sums and count alone
  assign room            = (cnt_q < ravc_pkg::CntW'(ravc_pkg::MaxPixels));
  assign cnt_nxt         = (accept && room) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    lane_ctrl.acc_en = accept && room;
    lane_ctrl.load   = accept && s_axis_tlast_i;
    lane_ctrl.step   = (state_q == ravc_pkg::StDiv);
    merge_load       = (state_q == ravc_pkg::StHold) && merge_free;

    state_d = state_q;
    cnt_d   = cnt_nxt;
    dsh_d   = dsh_q;
    step_d  = step_q;
    case (state_q)
      ravc_pkg::StIdle: begin
        if (lane_ctrl.load) begin
          state_d = ravc_pkg::StDiv;
          cnt_d   = '0;
          // first trial compares against count * 2^(MeanW-1)
          dsh_d   = ravc_pkg::CmpW'(cnt_nxt) << (ravc_pkg::MeanW - 1);
          step_d  = '0;
        end
      end
      ravc_pkg::StDiv: begin
        dsh_d  = dsh_q >> 1;
        step_d = step_q + 1'b1;
        if (step_q == ravc_pkg::StepW'(ravc_pkg::MeanW - 1)) begin
          state_d = ravc_pkg::StHold;
        end
      end
      ravc_pkg::StHold: begin
        if (merge_free) begin
          state_d = ravc_pkg::StIdle;
        end
      end
      default: begin
        state_d = ravc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ravc_pkg::StIdle;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsh_q <= dsh_d;
  end

  for (genvar l = 0; l < ravc_pkg::NumLanes; l++) begin : g_lane
    ravc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .pix_i  (s_axis_tdata_i[l*ravc_pkg::PixW +: ravc_pkg::PixW]),
      .dsh_i  (dsh_q),
      .quo_o  (quo[l])
    );
  end

  ravc_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (merge_load),
    .quo_i           (quo),
    .free_o          (merge_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ rtl/ravc_checker.sv @@
// Port-level checker for the RGBA average colour block, bound to the top.
// Depends on rgba_average_color's ports only.
`default_nettype none

module ravc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        s_axis_tlast_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o
);

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat dropped or changed under stall");

  // the division keeps the input side closed after a last beat is taken
  a_div_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |->
      ##1 !s_axis_tready_o ##1 !s_axis_tready_o ##1 !s_axis_tready_o
      ##1 !s_axis_tready_o ##1 !s_axis_tready_o ##1 !s_axis_tready_o
      ##1 !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("input taken during division");

  // a new result only appears out of a busy phase
  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a division");

  // the input side is open again in the same cycle that a fresh result appears
  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("input side not reopened after result");

endmodule

bind rgba_average_color ravc_checker u_ravc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

@@ tb/rgba_average_color_tb.sv @@
// Self-checking testbench for rgba_average_color: drives RGBA pixel pictures,
// predicts the per-channel truncated means and checks every output beat.
// Depends on ravc_pkg and the rgba_average_color RTL.
`default_nettype none

module rgba_average_color_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one pixel as it sits on tdata: red in the low byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready_o;
  pixel_t      s_axis_tdata;     // red, green, blue, alpha
  logic        s_axis_tlast;     // last_pixel
  logic        m_axis_tvalid_o;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata_o;   // mean_red, mean_green, mean_blue, mean_alpha

  // running picture state of the predictor
  longint unsigned chan_sum [ravc_pkg::NumLanes];
  longint unsigned pix_count;
  pixel_t          pending_means [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned cycle_count;

  rgba_average_color DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------
  // Predictor: accumulate an accepted pixel; on the last one queue the
  // expected means and clear for the next picture. Once the count has hit
  // the bound, pixels are dropped but a last flag still closes the picture.
  // --------------------------------------------------------------------
  function automatic void accumulate_pixel(input pixel_t px, input logic last);
    pixel_t          means;
    longint unsigned q;
    if (pix_count < ravc_pkg::MaxPixels) begin
      chan_sum[0] += px.red;
      chan_sum[1] += px.green;
      chan_sum[2] += px.blue;
      chan_sum[3] += px.alpha;
      pix_count   += 1;
    end
    if (last) begin
      for (int c = 0; c < ravc_pkg::NumLanes; c++) begin
        q = (pix_count == 0) ? 0 : chan_sum[c] / pix_count;
        if (q > 255) q = 255;
        means[c*8 +: 8] = q[7:0];
        chan_sum[c] = 0;
      end
      pix_count = 0;
      pending_means = {pending_means, means};
    end
  endfunction

  // --------------------------------------------------------------------
  // Sender: one pixel beat, with random idle cycles ahead of it. tvalid is
  // left high on return so back-to-back beats never drop it in between.
  // --------------------------------------------------------------------
  task automatic send_pixel(input pixel_t px, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    accumulate_pixel(px, last);
  endtask

  task automatic wait_means_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
  endtask

  // channel value biased towards the extremes
  function automatic logic [7:0] chan_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return 8'd0;
    if (r < 4) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red   = chan_value();
    px.green = chan_value();
    px.blue  = chan_value();
    px.alpha = chan_value();
    return px;
  endfunction

  // --------------------------------------------------------------------
  // Receiver: random stalls on the result side
  // --------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------
  // Checker: every accepted result beat against the oldest expectation
  // --------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t want;
    pixel_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got = m_axis_tdata_o;
      if (pending_means.size() == 0) begin
        $error("mean beat with none expected: %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        want = pending_means.pop_front();
        if (got.red !== want.red) begin
          $error("mean_red: expected %0d, got %0d", want.red, got.red);
          fail_count++;
        end
        if (got.green !== want.green) begin
          $error("mean_green: expected %0d, got %0d", want.green, got.green);
          fail_count++;
        end
        if (got.blue !== want.blue) begin
          $error("mean_blue: expected %0d, got %0d", want.blue, got.blue);
          fail_count++;
        end
        if (got.alpha !== want.alpha) begin
          $error("mean_alpha: expected %0d, got %0d", want.alpha, got.alpha);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------

  // one-pixel pictures: the mean is the pixel itself, all-zero and all-ones
  // included; back to back so the division stall shows on the input side
  task automatic test_single_pixel_pictures();
    send_pixel('{alpha: 8'd0,   blue: 8'd0,   green: 8'd0,   red: 8'd0},   1'b1);
    send_pixel('{alpha: 8'd255, blue: 8'd255, green: 8'd255, red: 8'd255}, 1'b1);
    send_pixel('{alpha: 8'd0,   blue: 8'd255, green: 8'd0,   red: 8'd255}, 1'b1);
    send_pixel('{alpha: 8'd255, blue: 8'd0,   green: 8'd255, red: 8'd0},   1'b1);
    send_pixel('{alpha: 8'h5a,  blue: 8'ha5,  green: 8'h3c,  red: 8'hc3},  1'b1);
  endtask

  // short pictures where the division truncates
  task automatic test_truncated_means();
    send_pixel('{alpha: 8'd0,   blue: 8'd255, green: 8'd0,   red: 8'd255}, 1'b0);
    send_pixel('{alpha: 8'd255, blue: 8'd0,   green: 8'd255, red: 8'd0},   1'b1);
    send_pixel('{alpha: 8'd4,   blue: 8'd3,   green: 8'd2,   red: 8'd1},   1'b0);
    send_pixel('{alpha: 8'd5,   blue: 8'd4,   green: 8'd3,   red: 8'd2},   1'b1);
    send_pixel('{alpha: 8'd0,   blue: 8'd1,   green: 8'd254, red: 8'd255}, 1'b0);
    send_pixel('{alpha: 8'd0,   blue: 8'd0,   green: 8'd255, red: 8'd255}, 1'b0);
    send_pixel('{alpha: 8'd1,   blue: 8'd0,   green: 8'd255, red: 8'd254}, 1'b1);
    // seven pixels of 255 and one of 254: mean just below the top
    for (int i = 0; i < 7; i++)
      send_pixel('{alpha: 8'd255, blue: 8'd255, green: 8'd255, red: 8'd255}, 1'b0);
    send_pixel('{alpha: 8'd254, blue: 8'd254, green: 8'd254, red: 8'd254}, 1'b1);
  endtask

  // random pictures, mostly short, now and then long
  task automatic test_random_pictures(input int unsigned n_pixels);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sent = 0;
    while (sent < n_pixels) begin
      r = $urandom_range(99);
      if (r < 70)      len = $urandom_range(6, 1);
      else if (r < 95) len = $urandom_range(40, 7);
      else             len = $urandom_range(200, 41);
      for (int i = 0; i < len; i++)
        send_pixel(rand_pixel(), i == len - 1);
      sent += len;
    end
  endtask

  // sender holds off until every mean is back, then resumes
  task automatic test_drain_pause();
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 4; i++)
        send_pixel(rand_pixel(), i == 3);
      wait_means_drained();
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    cycle_count    = 0;
    pix_count      = 0;
    for (int c = 0; c < ravc_pkg::NumLanes; c++) chan_sum[c] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_pixel_pictures();
    test_truncated_means();

    // no idling
    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_pictures(300);
    // sender idle
    send_idle_pct = 61; recv_stall_pct = 0;
    test_random_pictures(300);
    test_drain_pause();
    // receiver stalling
    send_idle_pct = 0;  recv_stall_pct = 61;
    test_random_pictures(300);
    // both
    send_idle_pct = 15; recv_stall_pct = 15;
    test_random_pictures(300);

    wait_means_drained();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
